// ===== src/multi_click_key_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// multi click key tracker assertion macros
// shared concurrent assertion forms, clocked on the rising edge with an
// active-low asynchronous reset disable
// ----------------------------------------------------------------------------
`ifndef MULTI_CLICK_KEY_TRACKER_MACROS_SVH
`define MULTI_CLICK_KEY_TRACKER_MACROS_SVH

// property must hold at every edge out of reset
`define MCKT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("mckt assertion failed");

// antecedent implies consequent in the next cycle
`define MCKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mckt assertion failed");

`endif

// ===== src/mckt_pkg.sv =====
// ----------------------------------------------------------------------------
// mckt_pkg
// shared types and constants of the multi click key tracker
// ----------------------------------------------------------------------------
package mckt_pkg;

  // click counter width
  localparam int unsigned CNT_W = 8;
  // key code width on the port
  localparam int unsigned KEY_CODE_W = 8;
  // click window register width and reset value
  localparam int unsigned WIN_W = 16;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd250;

  // item commands
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_PEEK_X = 2'd3
  } cmd_e;

  // control sequencer states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  // modifier key codes: ctrl group, shift group, alt group
  localparam int unsigned NUM_MODS = 9;
  localparam logic [KEY_CODE_W-1:0] MOD_CODES [NUM_MODS] = '{
    8'h11, 8'hA2, 8'hA3,
    8'h10, 8'hA0, 8'hA1,
    8'h12, 8'hA4, 8'hA5
  };

endpackage

// ===== src/mckt_entry_mem.sv =====
// ----------------------------------------------------------------------------
// mckt_entry_mem
// per-key entry memory, one write and one read port, registered read data;
// an entry never written since reset reads as zero through its valid bit
// ----------------------------------------------------------------------------
module mckt_entry_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 49
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_valid_q;

  // storage array and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== src/multi_click_key_tracker.sv =====
// ----------------------------------------------------------------------------
// multi_click_key_tracker
// multi-click table: per-key held level, live and buffered click counts and
// last press time, kept in one entry memory updated by read-modify-write
// ----------------------------------------------------------------------------
// result strobe: done_q is registered from the update state entered at the accepting edge
// busy: no new item is taken until the read then write-back pass on the single
//   entry memory is done
// reset: all counts, held levels and times read as zero, window 250 ms;
//   no clearing pass, the block takes items right after reset
// the receiver cannot stall: each result shows for one cycle on done_o
module multi_click_key_tracker #(
  parameter int unsigned NUM_KEYS  = 256,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [mckt_pkg::WIN_W-1:0]       cfg_wdata_i,
  // command side
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       cmd_i,
  input  logic [mckt_pkg::KEY_CODE_W-1:0]  key_i,
  input  logic                             pressed_i,
  input  logic [31:0]                      now_ms_i,
  input  logic [mckt_pkg::CNT_W-1:0]       target_count_i,
  input  logic                             want_ctrl_i,
  input  logic                             want_shift_i,
  input  logic                             want_alt_i,
  // result side
  output logic                             done_o,
  output logic                             key_held_o,
  output logic [mckt_pkg::CNT_W-1:0]       live_count_o,
  output logic                             matched_o
);

`include "multi_click_key_tracker_macros.svh"

  localparam int unsigned KEY_W  = $clog2(NUM_KEYS);
  localparam int unsigned CNT_W  = mckt_pkg::CNT_W;
  localparam int unsigned DATA_W = 1 + 2 * CNT_W + TIME_BITS;
  localparam int unsigned CMP_W  = TIME_BITS + 1;
  localparam int unsigned NMOD   = mckt_pkg::NUM_MODS;
  localparam logic [mckt_pkg::KEY_CODE_W:0] KEY_LIMIT =
    (mckt_pkg::KEY_CODE_W + 1)'(NUM_KEYS);

  // sequencer
  mckt_pkg::state_e state_q, state_d;
  logic             accept;
  logic             update;

  // captured item
  mckt_pkg::cmd_e                  cmd_q;
  logic [mckt_pkg::KEY_CODE_W-1:0] key_q;
  logic                            in_range_q;
  logic                            pressed_q;
  logic [TIME_BITS-1:0]            now_q;
  logic [CNT_W-1:0]                target_q;
  logic                            want_ctrl_q, want_shift_q, want_alt_q;

  // configuration and modifier shadow
  logic [mckt_pkg::WIN_W-1:0] win_q;
  logic [NMOD-1:0]            mod_held_q;

  // entry memory
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] wr_word;
  logic              wr_en;

  // entry fields
  logic                 ent_held;
  logic [CNT_W-1:0]     ent_live, ent_buf;
  logic [TIME_BITS-1:0] ent_last;
  logic                 new_held;
  logic [CNT_W-1:0]     new_live, new_buf;
  logic [TIME_BITS-1:0] new_last;

  // ageing and check terms
  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     el_ext, win_ext, win2_ext;
  logic                 ctrl_dn, shift_dn, alt_dn;
  logic                 hit;

  // result registers
  logic             done_q;
  logic             key_held_q;
  logic [CNT_W-1:0] live_count_q;
  logic             matched_q;

  assign accept = start && !busy;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mckt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_d = state_q;
    busy    = 1'b0;
    update  = 1'b0;
    unique case (state_q)
      mckt_pkg::ST_IDLE: begin
        if (start) begin
          state_d = mckt_pkg::ST_UPDATE;
        end
      end
      mckt_pkg::ST_UPDATE: begin
        busy    = 1'b1;
        update  = 1'b1;
        state_d = mckt_pkg::ST_IDLE;
      end
      default: begin
        state_d = mckt_pkg::ST_IDLE;
      end
    endcase
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q        <= mckt_pkg::cmd_e'(cmd_i);
      key_q        <= key_i;
      in_range_q   <= {1'b0, key_i} < KEY_LIMIT;
      pressed_q    <= pressed_i;
      now_q        <= now_ms_i[TIME_BITS-1:0];
      target_q     <= target_count_i;
      want_ctrl_q  <= want_ctrl_i;
      want_shift_q <= want_shift_i;
      want_alt_q   <= want_alt_i;
    end
  end

  // click window register, zero writes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= mckt_pkg::WINDOW_RESET;
    end else if (cfg_we_i && (cfg_wdata_i != '0)) begin
      win_q <= cfg_wdata_i;
    end
  end

  // held levels of the modifier keys, tracked beside the memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_held_q <= '0;
    end else if (update && in_range_q && (cmd_q == mckt_pkg::CMD_SAMPLE)) begin
      for (int i = 0; i < NMOD; i++) begin
        if (key_q == mckt_pkg::MOD_CODES[i]) begin
          mod_held_q[i] <= pressed_q;
        end
      end
    end
  end

  assign ctrl_dn  = |mod_held_q[2:0];
  assign shift_dn = |mod_held_q[5:3];
  assign alt_dn   = |mod_held_q[8:6];

  mckt_entry_mem #(
    .DEPTH  (NUM_KEYS),
    .ADDR_W (KEY_W),
    .DATA_W (DATA_W)
  ) u_entry_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (key_i[KEY_W-1:0]),
    .rd_data_o (rd_word),
    .wr_en_i   (wr_en),
    .wr_addr_i (key_q[KEY_W-1:0]),
    .wr_data_i (wr_word)
  );

  // entry word layout: held, live, buffered, last press time
  assign {ent_held, ent_live, ent_buf, ent_last} = rd_word;

  // elapsed time since the last press, wrapping
  assign elapsed  = now_q - ent_last;
  assign el_ext   = {1'b0, elapsed};
  assign win_ext  = {{(CMP_W - mckt_pkg::WIN_W){1'b0}}, win_q};
  assign win2_ext = {win_ext[CMP_W-2:0], 1'b0};

  // modify step
  always_comb begin
    new_held = ent_held;
    new_live = ent_live;
    new_buf  = ent_buf;
    new_last = ent_last;
    hit      = 1'b0;
    unique case (cmd_q)
      mckt_pkg::CMD_SAMPLE: begin
        // age the click run
        if ((ent_buf != '0) && (el_ext > win2_ext)) begin
          new_buf = '0;
        end
        if ((ent_live != '0) && (el_ext > win_ext)) begin
          new_buf  = ent_live;
          new_live = '0;
        end
        // count rising edges, stamp presses
        if (pressed_q) begin
          if (!ent_held) begin
            new_live = new_live + CNT_W'(1);
          end
          new_held = 1'b1;
          new_last = now_q;
        end else begin
          new_held = 1'b0;
        end
      end
      mckt_pkg::CMD_CHECK: begin
        hit = (key_q != '0) && (target_q != '0) &&
              (want_ctrl_q == ctrl_dn) && (want_shift_q == shift_dn) &&
              (want_alt_q == alt_dn) && (ent_buf == target_q);
        if (hit) begin
          new_buf = '0;
        end
      end
      mckt_pkg::CMD_PEEK, mckt_pkg::CMD_PEEK_X: begin
      end
      default: begin
      end
    endcase
  end

  // write back
  assign wr_en   = update && in_range_q && ((cmd_q == mckt_pkg::CMD_SAMPLE) || hit);
  assign wr_word = {new_held, new_live, new_buf, new_last};

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= update;
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (update) begin
      key_held_q   <= in_range_q && new_held;
      live_count_q <= in_range_q ? new_live : '0;
      matched_q    <= in_range_q && hit;
    end
  end

  assign done_o       = done_q;
  assign key_held_o   = key_held_q;
  assign live_count_o = live_count_q;
  assign matched_o    = done_q && matched_q;

  // checks
  `MCKT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `MCKT_ASSERT_NEXT(a_busy_done, clk_i, rst_ni, busy, done_o && !busy)
  `MCKT_ASSERT(a_done_idle, clk_i, rst_ni, !done_o || !busy)
  `MCKT_ASSERT(a_write_in_update, clk_i, rst_ni, !wr_en || busy)

endmodule
